@@ hw/rtl/rbsi_pkg.sv @@
// Shared constants, codes and types of the ray versus cube slab test.
package rbsi_pkg;

	// Default number format: signed Q16.16 in 32 bits.
	localparam int COORD_W = 32;
	localparam int FRAC_W = 16;

	// Struck face codes.
	localparam logic [1:0] FACE_X = 2'd0;
	localparam logic [1:0] FACE_Y = 2'd1;
	localparam logic [1:0] FACE_Z = 2'd2;
	localparam logic [1:0] FACE_NONE = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] REG_CENTER_X = 2'd0;
	localparam logic [1:0] REG_CENTER_Y = 2'd1;
	localparam logic [1:0] REG_CENTER_Z = 2'd2;
	localparam logic [1:0] REG_BOX_SIZE = 2'd3;

	// Per-axis status that a lane hands to the merge stage.
	typedef struct packed {
		logic par;
		logic par_miss;
		logic dir_pos;
	} lane_flags_t;

	// Register stages of the slab divider for a given coordinate width.
	function automatic int div_latency(input int cw);
		return cw + 3;
	endfunction

endpackage

@@ hw/rtl/rbsi_ray_if.sv @@
// Ray input channel: valid/ready handshake with the ray payload.
interface rbsi_ray_if import rbsi_pkg::*; #(
	parameter int CW = COORD_W
);
	logic valid;
	logic ready;
	logic signed [CW-1:0] origin_x;
	logic signed [CW-1:0] origin_y;
	logic signed [CW-1:0] origin_z;
	logic signed [CW-1:0] dir_x;
	logic signed [CW-1:0] dir_y;
	logic signed [CW-1:0] dir_z;
	logic signed [CW-1:0] t_lower;
	logic signed [CW-1:0] t_upper;

	modport source (
		output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_lower, t_upper,
		input ready
	);
	modport sink (
		input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_lower, t_upper,
		output ready
	);
endinterface

@@ hw/rtl/rbsi_hit_if.sv @@
// Result channel: valid/ready handshake with the hit payload.
interface rbsi_hit_if import rbsi_pkg::*; #(
	parameter int CW = COORD_W
);
	logic valid;
	logic ready;
	logic hit;
	logic signed [CW-1:0] hit_t;
	logic signed [CW-1:0] point_x;
	logic signed [CW-1:0] point_y;
	logic signed [CW-1:0] point_z;
	logic [1:0] face_axis;
	logic face_negative;
	logic front_face;

	modport source (
		output valid, hit, hit_t, point_x, point_y, point_z, face_axis, face_negative,
		front_face,
		input ready
	);
	modport sink (
		input valid, hit, hit_t, point_x, point_y, point_z, face_axis, face_negative,
		front_face,
		output ready
	);
endinterface

@@ hw/rtl/rbsi_div.sv @@
// Pipelined signed divider, one quotient bit per stage, saturating result.
module rbsi_div import rbsi_pkg::*; #(
	parameter int CW = COORD_W,
	parameter int NW = COORD_W + FRAC_W + 2
) (
	input logic clk,
	input logic en,
	input logic signed [NW-1:0] num,
	input logic signed [CW-1:0] den,
	output logic signed [CW-1:0] quo
);
	localparam int RW = ((NW > 2 * CW) ? NW : 2 * CW) + 1;

	logic [NW-1:0] num_mag;
	logic [CW-1:0] den_mag;
	logic [NW-1:0] num_mag_s0;
	logic [CW-1:0] den_mag_s0;
	logic neg_s0;

	logic [RW-1:0] rem_s [0:CW];
	logic [CW-1:0] q_s [0:CW];
	logic [CW-1:0] den_s [0:CW];
	logic neg_s [0:CW];
	logic ovf_s [0:CW];

	logic [CW-1:0] q_fin;
	logic sat;
	logic signed [CW-1:0] quo_q;

	// Split both operands into sign and magnitude.
	always_comb begin
		num_mag = num[NW-1] ? (~$unsigned(num) + NW'(1)) : $unsigned(num);
		den_mag = den[CW-1] ? (~$unsigned(den) + CW'(1)) : $unsigned(den);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_mag_s0 <= num_mag;
			den_mag_s0 <= den_mag;
			neg_s0 <= num[NW-1] ^ den[CW-1];
		end
	end

	// A quotient of 2^CW or more is flagged here and saturates at the end.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= RW'(num_mag_s0);
			q_s[0] <= '0;
			den_s[0] <= den_mag_s0;
			neg_s[0] <= neg_s0;
			ovf_s[0] <= RW'(num_mag_s0) >= (RW'(den_mag_s0) << CW);
		end
	end

	// Restoring division, most significant quotient bit first.
	for (genvar j = 0; j < CW; j++) begin : g_bit
		localparam int B = CW - 1 - j;
		logic [RW-1:0] sub;
		logic ge;

		always_comb begin
			sub = RW'(den_s[j]) << B;
			ge = rem_s[j] >= sub;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1] <= ge ? (rem_s[j] - sub) : rem_s[j];
				q_s[j+1] <= q_s[j] | (CW'(ge) << B);
				den_s[j+1] <= den_s[j];
				neg_s[j+1] <= neg_s[j];
				ovf_s[j+1] <= ovf_s[j];
			end
		end
	end

	// Apply the sign and clamp to the coordinate range.
	always_comb begin
		q_fin = q_s[CW];
		sat = ovf_s[CW] | q_fin[CW-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (sat) begin
				quo_q <= neg_s[CW] ? $signed({1'b1, {(CW-1){1'b0}}}) :
					$signed({1'b0, {(CW-1){1'b1}}});
			end else begin
				quo_q <= neg_s[CW] ? $signed(~q_fin + CW'(1)) : $signed(q_fin);
			end
		end
	end

	assign quo = quo_q;
endmodule

@@ hw/rtl/rbsi_lane.sv @@
// One axis lane: slab bounds, two slab distances and the parallel test.
module rbsi_lane import rbsi_pkg::*; #(
	parameter int CW = COORD_W,
	parameter int FB = FRAC_W
) (
	input logic clk,
	input logic en,
	input logic signed [CW-1:0] center,
	input logic [CW-3:0] half,
	input logic signed [CW-1:0] org,
	input logic signed [CW-1:0] dir,
	output logic signed [CW-1:0] t_entry,
	output logic signed [CW-1:0] t_exit,
	output lane_flags_t flags
);
	localparam int NW = CW + 2 + FB;
	localparam int DL = div_latency(CW);

	logic signed [CW:0] lo;
	logic signed [CW:0] hi;
	logic signed [CW:0] org_e;
	logic signed [CW+1:0] diff_lo;
	logic signed [CW+1:0] diff_hi;
	logic signed [NW-1:0] num_lo;
	logic signed [NW-1:0] num_hi;
	logic signed [CW-1:0] q_lo;
	logic signed [CW-1:0] q_hi;
	lane_flags_t flags_in;
	lane_flags_t flags_s [0:DL-1];

	// Exact bounds, one bit wider than a coordinate, and scaled numerators.
	always_comb begin
		lo = $signed({center[CW-1], center}) - $signed({3'b000, half});
		hi = $signed({center[CW-1], center}) + $signed({3'b000, half});
		org_e = $signed({org[CW-1], org});
		diff_lo = $signed({lo[CW], lo}) - $signed({org_e[CW], org_e});
		diff_hi = $signed({hi[CW], hi}) - $signed({org_e[CW], org_e});
		num_lo = $signed({diff_lo, {FB{1'b0}}});
		num_hi = $signed({diff_hi, {FB{1'b0}}});
		flags_in.par = (dir == '0);
		flags_in.par_miss = (org_e < lo) || (org_e > hi);
		flags_in.dir_pos = !dir[CW-1] && (dir != '0);
	end

	rbsi_div #(.CW(CW), .NW(NW)) u_div_lo (
		.clk(clk), .en(en), .num(num_lo), .den(dir), .quo(q_lo)
	);

	rbsi_div #(.CW(CW), .NW(NW)) u_div_hi (
		.clk(clk), .en(en), .num(num_hi), .den(dir), .quo(q_hi)
	);

	// Flags travel alongside the dividers.
	always_ff @(posedge clk) begin
		if (en) begin
			flags_s[0] <= flags_in;
			for (int k = 1; k < DL; k++) begin
				flags_s[k] <= flags_s[k-1];
			end
		end
	end

	// Order the two distances into entry and exit.
	always_comb begin
		t_entry = (q_lo > q_hi) ? q_hi : q_lo;
		t_exit = (q_lo > q_hi) ? q_lo : q_hi;
		flags = flags_s[DL-1];
	end
endmodule

@@ hw/rtl/rbsi_merge.sv @@
// Merge of the three lanes: interval update, face choice and hit point.
module rbsi_merge import rbsi_pkg::*; #(
	parameter int CW = COORD_W,
	parameter int FB = FRAC_W
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic valid_in,
	input logic signed [CW-1:0] org [3],
	input logic signed [CW-1:0] dir [3],
	input logic signed [CW-1:0] t_lo,
	input logic signed [CW-1:0] t_hi,
	input logic signed [CW-1:0] t_entry [3],
	input logic signed [CW-1:0] t_exit [3],
	input lane_flags_t flags [3],
	output logic valid_out,
	output logic hit,
	output logic signed [CW-1:0] hit_t,
	output logic signed [CW-1:0] point [3],
	output logic [1:0] face_axis,
	output logic face_negative,
	output logic front_face
);
	logic signed [CW-1:0] t_near;
	logic signed [CW-1:0] t_far;
	logic signed [CW-1:0] t_sel;
	logic [1:0] face;
	logic neg;
	logic miss;

	logic valid_s1;
	logic miss_s1;
	logic signed [CW-1:0] t_hit_s1;
	logic [1:0] face_s1;
	logic neg_s1;
	logic signed [CW-1:0] org_s1 [3];
	logic signed [CW-1:0] dir_s1 [3];

	logic valid_s2;
	logic miss_s2;
	logic signed [CW-1:0] t_hit_s2;
	logic [1:0] face_s2;
	logic neg_s2;
	logic signed [CW-1:0] org_s2 [3];
	logic signed [2*CW-1:0] prod_s2 [3];

	// Walk the axes in order; a miss on any axis is final.
	always_comb begin
		t_near = t_lo;
		t_far = t_hi;
		face = FACE_NONE;
		neg = 1'b0;
		miss = 1'b0;
		for (int i = 0; i < 3; i++) begin
			if (flags[i].par) begin
				miss = miss | flags[i].par_miss;
			end else begin
				if (t_entry[i] > t_near) begin
					t_near = t_entry[i];
					face = 2'(i);
					neg = flags[i].dir_pos;
				end
				if (t_exit[i] < t_far) begin
					t_far = t_exit[i];
				end
				if (t_near > t_far) begin
					miss = 1'b1;
				end
			end
		end
		if ((t_near > t_hi) || (t_far < t_lo)) begin
			miss = 1'b1;
		end
		t_sel = (t_near > t_lo) ? t_near : t_far;
		if ((t_sel < t_lo) || (t_sel > t_hi)) begin
			miss = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
			valid_s2 <= valid_s1;
		end
	end

	// First stage holds the decision, second the products t * dir.
	always_ff @(posedge clk) begin
		if (en) begin
			miss_s1 <= miss;
			t_hit_s1 <= t_sel;
			face_s1 <= face;
			neg_s1 <= neg;
			org_s1 <= org;
			dir_s1 <= dir;
			miss_s2 <= miss_s1;
			t_hit_s2 <= t_hit_s1;
			face_s2 <= face_s1;
			neg_s2 <= neg_s1;
			org_s2 <= org_s1;
			for (int i = 0; i < 3; i++) begin
				prod_s2[i] <= t_hit_s1 * dir_s1[i];
			end
		end
	end

	// Hit point: floor shift of the product, add origin, clamp.
	for (genvar i = 0; i < 3; i++) begin : g_point
		logic signed [2*CW-1:0] shifted;
		logic signed [2*CW:0] sum;
		logic [CW+1:0] top;
		logic signed [CW-1:0] p;

		always_comb begin
			shifted = prod_s2[i] >>> FB;
			sum = $signed({shifted[2*CW-1], shifted}) +
				$signed({{(CW+1){org_s2[i][CW-1]}}, org_s2[i]});
			top = sum[2*CW:CW-1];
			if ((top == '0) || (top == '1)) begin
				p = sum[CW-1:0];
			end else begin
				p = sum[2*CW] ? $signed({1'b1, {(CW-1){1'b0}}}) :
					$signed({1'b0, {(CW-1){1'b1}}});
			end
			point[i] = miss_s2 ? '0 : p;
		end
	end

	always_comb begin
		valid_out = valid_s2;
		hit = !miss_s2;
		hit_t = miss_s2 ? '0 : t_hit_s2;
		face_axis = miss_s2 ? FACE_NONE : face_s2;
		face_negative = (miss_s2 || face_s2 == FACE_NONE) ? 1'b0 : neg_s2;
		front_face = (miss_s2 || face_s2 == FACE_NONE) ? 1'b0 : 1'b1;
	end
endmodule

@@ hw/rtl/ray_box_slab_intersect_top.sv @@
// Top level of the ray versus axis-aligned cube slab test.
// Tests one ray per clock against a cube set by its center and edge size over
// the APB port. The three axes run in parallel lanes, each with two pipelined
// dividers that produce one quotient bit per stage. The default format is
// Q16.16. From acceptance to result a ray passes one input register,
// COORD_WIDTH + 3 divider stages, two merge stages (decision, then the
// hit-point multipliers) and a two-entry output queue. A new ray is taken
// every cycle unless the output queue is full.
module ray_box_slab_intersect_top import rbsi_pkg::*; #(
	parameter int COORD_WIDTH = COORD_W,
	parameter int FRAC_BITS = FRAC_W,
	localparam int PDW = (COORD_WIDTH > 32) ? 64 : 32,
	localparam int PAW = (COORD_WIDTH > 32) ? 5 : 4
) (
	input logic clk,
	input logic arst_n,
	rbsi_ray_if.sink ray,
	rbsi_hit_if.source res,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [PAW-1:0] paddr,
	input logic [PDW-1:0] pwdata,
	output logic [PDW-1:0] prdata,
	output logic pready
);
	localparam int CW = COORD_WIDTH;
	localparam int DL = div_latency(CW);

	logic signed [CW-1:0] center_x_q;
	logic signed [CW-1:0] center_y_q;
	logic signed [CW-1:0] center_z_q;
	logic [CW-2:0] box_size_q;
	logic [1:0] reg_idx;
	logic wr_en;

	logic en;
	logic full;

	logic valid_s1;
	logic signed [CW-1:0] org_s1 [3];
	logic signed [CW-1:0] dir_s1 [3];
	logic signed [CW-1:0] t_lo_s1;
	logic signed [CW-1:0] t_hi_s1;

	logic valid_d [0:DL-1];
	logic signed [CW-1:0] org_d [0:DL-1][3];
	logic signed [CW-1:0] dir_d [0:DL-1][3];
	logic signed [CW-1:0] t_lo_d [0:DL-1];
	logic signed [CW-1:0] t_hi_d [0:DL-1];

	logic signed [CW-1:0] centers [3];
	logic signed [CW-1:0] t_entry [3];
	logic signed [CW-1:0] t_exit [3];
	lane_flags_t flags [3];

	logic m_valid;
	logic m_hit;
	logic signed [CW-1:0] m_hit_t;
	logic signed [CW-1:0] m_point [3];
	logic [1:0] m_face;
	logic m_neg;
	logic m_front;

	logic fifo_hit_q [2];
	logic signed [CW-1:0] fifo_t_q [2];
	logic signed [CW-1:0] fifo_px_q [2];
	logic signed [CW-1:0] fifo_py_q [2];
	logic signed [CW-1:0] fifo_pz_q [2];
	logic [1:0] fifo_face_q [2];
	logic fifo_neg_q [2];
	logic fifo_front_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] cnt_q;
	logic push;
	logic pop;

	// Configuration registers.
	assign reg_idx = paddr[PAW-1:PAW-2];
	assign wr_en = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			center_z_q <= '0;
			box_size_q <= (CW-1)'(1) << FRAC_BITS;
		end else if (wr_en) begin
			case (reg_idx)
				REG_CENTER_X: center_x_q <= $signed(pwdata[CW-1:0]);
				REG_CENTER_Y: center_y_q <= $signed(pwdata[CW-1:0]);
				REG_CENTER_Z: center_z_q <= $signed(pwdata[CW-1:0]);
				REG_BOX_SIZE: box_size_q <= pwdata[CW-2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_CENTER_X: prdata = PDW'($unsigned(center_x_q));
			REG_CENTER_Y: prdata = PDW'($unsigned(center_y_q));
			REG_CENTER_Z: prdata = PDW'($unsigned(center_z_q));
			REG_BOX_SIZE: prdata = PDW'(box_size_q);
			default: prdata = '0;
		endcase
	end

	// The whole pipeline moves together while the output queue has room.
	assign full = (cnt_q == 2'd2);
	assign en = !full;
	assign ray.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			for (int k = 0; k < DL; k++) begin
				valid_d[k] <= 1'b0;
			end
		end else if (en) begin
			valid_s1 <= ray.valid;
			valid_d[0] <= valid_s1;
			for (int k = 1; k < DL; k++) begin
				valid_d[k] <= valid_d[k-1];
			end
		end
	end

	// Input register and the ray payload delayed to meet the divider results.
	always_ff @(posedge clk) begin
		if (en) begin
			org_s1[0] <= ray.origin_x;
			org_s1[1] <= ray.origin_y;
			org_s1[2] <= ray.origin_z;
			dir_s1[0] <= ray.dir_x;
			dir_s1[1] <= ray.dir_y;
			dir_s1[2] <= ray.dir_z;
			t_lo_s1 <= ray.t_lower;
			t_hi_s1 <= ray.t_upper;
			org_d[0] <= org_s1;
			dir_d[0] <= dir_s1;
			t_lo_d[0] <= t_lo_s1;
			t_hi_d[0] <= t_hi_s1;
			for (int k = 1; k < DL; k++) begin
				org_d[k] <= org_d[k-1];
				dir_d[k] <= dir_d[k-1];
				t_lo_d[k] <= t_lo_d[k-1];
				t_hi_d[k] <= t_hi_d[k-1];
			end
		end
	end

	// One lane per axis.
	assign centers[0] = center_x_q;
	assign centers[1] = center_y_q;
	assign centers[2] = center_z_q;

	for (genvar i = 0; i < 3; i++) begin : g_lane
		rbsi_lane #(.CW(CW), .FB(FRAC_BITS)) u_lane (
			.clk(clk),
			.en(en),
			.center(centers[i]),
			.half(box_size_q[CW-2:1]),
			.org(org_s1[i]),
			.dir(dir_s1[i]),
			.t_entry(t_entry[i]),
			.t_exit(t_exit[i]),
			.flags(flags[i])
		);
	end

	rbsi_merge #(.CW(CW), .FB(FRAC_BITS)) u_merge (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.valid_in(valid_d[DL-1]),
		.org(org_d[DL-1]),
		.dir(dir_d[DL-1]),
		.t_lo(t_lo_d[DL-1]),
		.t_hi(t_hi_d[DL-1]),
		.t_entry(t_entry),
		.t_exit(t_exit),
		.flags(flags),
		.valid_out(m_valid),
		.hit(m_hit),
		.hit_t(m_hit_t),
		.point(m_point),
		.face_axis(m_face),
		.face_negative(m_neg),
		.front_face(m_front)
	);

	// Two-entry output queue decouples the result channel from the pipeline.
	assign push = m_valid && en;
	assign pop = res.valid && res.ready;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_hit_q[wr_ptr_q] <= m_hit;
			fifo_t_q[wr_ptr_q] <= m_hit_t;
			fifo_px_q[wr_ptr_q] <= m_point[0];
			fifo_py_q[wr_ptr_q] <= m_point[1];
			fifo_pz_q[wr_ptr_q] <= m_point[2];
			fifo_face_q[wr_ptr_q] <= m_face;
			fifo_neg_q[wr_ptr_q] <= m_neg;
			fifo_front_q[wr_ptr_q] <= m_front;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	assign res.valid = (cnt_q != 2'd0);
	assign res.hit = fifo_hit_q[rd_ptr_q];
	assign res.hit_t = fifo_t_q[rd_ptr_q];
	assign res.point_x = fifo_px_q[rd_ptr_q];
	assign res.point_y = fifo_py_q[rd_ptr_q];
	assign res.point_z = fifo_pz_q[rd_ptr_q];
	assign res.face_axis = fifo_face_q[rd_ptr_q];
	assign res.face_negative = fifo_neg_q[rd_ptr_q];
	assign res.front_face = fifo_front_q[rd_ptr_q];

	// A miss carries no distance and no face.
	a_miss_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.hit) |->
		(res.hit_t == '0 && res.face_axis == FACE_NONE && !res.front_face))
		else $error("miss result carries hit data");

	// A hit is front facing exactly when an entry face was found.
	a_front_face: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.hit) |-> (res.front_face == (res.face_axis != FACE_NONE)))
		else $error("front_face disagrees with face_axis");

	// The input side only stalls while results wait to be taken.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!ray.ready |-> res.valid)
		else $error("input stalled with no result pending");
endmodule
